### hdl/psieve_pkg.sv
package psieve_pkg;

    // Number of filter cells in the chain.
    localparam int CELLS       = 16;
    // Width of the value each cell works on and stores.
    localparam int VALUE_WIDTH = 16;
    // Width of the candidate and prime fields on the stream ports.
    localparam int DATA_WIDTH  = 16;
    // Common width used to move between the port field and the cell value.
    localparam int EXT_WIDTH   = (VALUE_WIDTH > DATA_WIDTH) ? VALUE_WIDTH : DATA_WIDTH;
    // Bit counter for the serial feed, most significant bit first.
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    // One bit of a candidate traveling down the chain, together with the
    // verdict flags that ride along with its last bit.
    typedef struct packed {
        logic vld;     // token carries a bit
        logic dbit;    // candidate bit
        logic first;   // most significant bit of the candidate
        logic last;    // least significant bit of the candidate
        logic kill;    // some cell divides the candidate, or it is below two
        logic stored;  // some cell has taken the candidate as its prime
        logic eos;     // empty the cells once this candidate has passed
    } t_tok;

endpackage

### hdl/pipelined_prime_sieve_core.sv
// Channel   Direction  Ports                         Contents
// s         in         i_s_tvalid/o_s_tready         tdata: candidate[15:0]
//                      i_s_tdata, i_s_tlast          tlast: end_of_stream
// m         out        o_m_tvalid/i_m_tready         tdata: prime_value[15:0]
//                      o_m_tdata, o_m_tuser          tuser: unchecked
//
// Each accepted beat must finish before the next beat is taken: the
// candidate is fed serially, one bit per cycle, and its last bit must
// ripple through every cell of the chain before the verdict is known.
// Reset is synchronous and active low; it empties every cell.
// A finished result waits in the output register, with one hold register
// behind it, so a new candidate is taken while the output is stalled.
module pipelined_prime_sieve_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [psieve_pkg::DATA_WIDTH-1:0] i_s_tdata,   // [15:0] candidate
    input  logic                              i_s_tlast,   // end_of_stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [psieve_pkg::DATA_WIDTH-1:0] o_m_tdata,   // [15:0] prime_value
    output logic                              o_m_tuser    // [0] unchecked
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_WAIT
    } t_state;

    t_state                               r_state;
    logic [psieve_pkg::CNT_WIDTH-1:0]     r_cnt;
    logic [psieve_pkg::VALUE_WIDTH-1:0]   r_shift;
    logic [psieve_pkg::VALUE_WIDTH-1:0]   r_value;
    logic                                 r_small;
    logic                                 r_eos;
    logic                                 r_o_valid;
    logic [psieve_pkg::DATA_WIDTH-1:0]    r_o_data;
    logic                                 r_o_flag;
    logic                                 r_h_valid;
    logic [psieve_pkg::DATA_WIDTH-1:0]    r_h_data;
    logic                                 r_h_flag;

    logic [psieve_pkg::EXT_WIDTH-1:0]     cand_ext;
    logic [psieve_pkg::VALUE_WIDTH-1:0]   cand_val;
    logic [psieve_pkg::EXT_WIDTH-1:0]     res_ext;
    logic [psieve_pkg::DATA_WIDTH-1:0]    res_data;
    logic                                 in_acc;
    logic                                 drain;
    logic                                 done;
    logic                                 emit;
    logic                                 res_flag;

    psieve_pkg::t_tok                     w_tok [psieve_pkg::CELLS+1];

    // The candidate is taken modulo 2^VALUE_WIDTH; the result is cut back to
    // the port width.
    assign cand_ext = psieve_pkg::EXT_WIDTH'(i_s_tdata);
    assign cand_val = cand_ext[psieve_pkg::VALUE_WIDTH-1:0];
    assign res_ext  = psieve_pkg::EXT_WIDTH'(r_value);
    assign res_data = res_ext[psieve_pkg::DATA_WIDTH-1:0];

    // A new candidate is taken only when the chain is free and there is room
    // for its result even if the output stays stalled.
    assign o_s_tready = (r_state == ST_IDLE) && !r_h_valid;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign drain      = r_o_valid && i_m_tready;

    // Serial feed into the first cell, most significant bit first. The
    // below-two check is made up front and enters the chain as a kill.
    always_comb begin
        w_tok[0]        = '0;
        w_tok[0].vld    = (r_state == ST_SHIFT);
        w_tok[0].dbit   = r_shift[psieve_pkg::VALUE_WIDTH-1];
        w_tok[0].first  = (r_cnt == psieve_pkg::CNT_WIDTH'(psieve_pkg::VALUE_WIDTH - 1));
        w_tok[0].last   = (r_cnt == '0);
        w_tok[0].kill   = r_small;
        w_tok[0].stored = 1'b0;
        w_tok[0].eos    = r_eos;
    end

    for (genvar g = 0; g < psieve_pkg::CELLS; g++) begin : g_cell
        psieve_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // The last bit leaving the final cell carries the verdict. A survivor
    // that found no empty cell is reported as unchecked.
    assign done     = w_tok[psieve_pkg::CELLS].vld && w_tok[psieve_pkg::CELLS].last;
    assign emit     = done && !w_tok[psieve_pkg::CELLS].kill;
    assign res_flag = !w_tok[psieve_pkg::CELLS].stored;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_h_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_shift <= cand_val;
                        r_value <= cand_val;
                        r_small <= (cand_val[psieve_pkg::VALUE_WIDTH-1:1] == '0);
                        r_eos   <= i_s_tlast;
                        r_cnt   <= psieve_pkg::CNT_WIDTH'(psieve_pkg::VALUE_WIDTH - 1);
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    r_shift <= {r_shift[psieve_pkg::VALUE_WIDTH-2:0], 1'b0};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // Output register with one hold register behind it. The hold
            // register is always empty when a verdict arrives, because a
            // candidate is taken only while it is empty.
            if (emit && (!r_o_valid || drain)) begin
                r_o_valid <= 1'b1;
                r_o_data  <= res_data;
                r_o_flag  <= res_flag;
            end else if (emit) begin
                r_h_valid <= 1'b1;
                r_h_data  <= res_data;
                r_h_flag  <= res_flag;
            end else if (drain) begin
                if (r_h_valid) begin
                    r_o_data  <= r_h_data;
                    r_o_flag  <= r_h_flag;
                    r_h_valid <= 1'b0;
                end else begin
                    r_o_valid <= 1'b0;
                end
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_flag;

endmodule

### hdl/psieve_cell.sv
module psieve_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psieve_pkg::t_tok  i_tok,
    output psieve_pkg::t_tok  o_tok
);

    logic [psieve_pkg::VALUE_WIDTH-1:0] r_prime;
    logic [psieve_pkg::VALUE_WIDTH-1:0] r_rem;
    psieve_pkg::t_tok                   r_tok;

    logic [psieve_pkg::VALUE_WIDTH:0]   trial;
    logic [psieve_pkg::VALUE_WIDTH:0]   diff;
    logic [psieve_pkg::VALUE_WIDTH-1:0] n_rem;
    logic [psieve_pkg::VALUE_WIDTH-1:0] n_prime;
    logic                               own_div;
    logic                               take;
    psieve_pkg::t_tok                   n_tok;

    // One restoring-division step per bit. An empty cell divides by zero,
    // which never subtracts, so its remainder register collects the whole
    // candidate and is ready to be stored when the last bit arrives.
    always_comb begin
        trial   = {(i_tok.first ? '0 : r_rem), i_tok.dbit};
        diff    = trial - {1'b0, r_prime};
        if (trial >= {1'b0, r_prime}) begin
            n_rem = diff[psieve_pkg::VALUE_WIDTH-1:0];
        end else begin
            n_rem = trial[psieve_pkg::VALUE_WIDTH-1:0];
        end
        own_div = (r_prime != '0) && (n_rem == '0);
        take    = (r_prime == '0) && !i_tok.kill && !i_tok.stored;

        n_tok   = i_tok;
        n_prime = r_prime;
        if (i_tok.vld && i_tok.last) begin
            n_tok.kill   = i_tok.kill | own_div;
            n_tok.stored = i_tok.stored | take;
            if (i_tok.eos) begin
                n_prime = '0;
            end else if (take) begin
                n_prime = n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= '0;
            r_tok   <= '0;
        end else begin
            r_prime <= n_prime;
            r_tok   <= n_tok;
            if (i_tok.vld) begin
                r_rem <= n_rem;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

### hdl/psieve_checker.sv
module psieve_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [psieve_pkg::DATA_WIDTH-1:0] i_s_tdata,
    input logic                              i_s_tlast,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [psieve_pkg::DATA_WIDTH-1:0] o_m_tdata,
    input logic                              o_m_tuser
);

    // A result beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    // One candidate at a time: the input closes right after a beat is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second candidate taken while one is in the chain");

    // A verdict needs the whole chain, so no result appears just after a beat.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(i_s_tvalid && o_s_tready))
        else $error("result appeared too soon after a candidate");

    // Reset leaves no result on offer.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered after reset");

endmodule

bind pipelined_prime_sieve_core psieve_checker u_psieve_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
